### src/ailms_pkg.sv
package ailms_pkg;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_W     = 16;
    localparam int TAPS_W     = 3;
    localparam int STEP_FRAC  = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_STEP_SIZE   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TAPS_IN_USE = 2'd1;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;
    localparam logic [TAPS_W-1:0] TAPS_RESET = 3'd4;

    typedef logic [2:0] t_pc;

    localparam t_pc PC_WAIT = 3'd0;
    localparam t_pc PC_MACB = 3'd1;
    localparam t_pc PC_MACA = 3'd2;
    localparam t_pc PC_OUT  = 3'd3;
    localparam t_pc PC_GAIN = 3'd4;
    localparam t_pc PC_UPDB = 3'd5;
    localparam t_pc PC_UPDA = 3'd6;

    typedef enum logic [2:0] {
        OP_WAIT,
        OP_MAC_B,
        OP_MAC_A,
        OP_OUT,
        OP_GAIN,
        OP_UPD_B,
        OP_UPD_A
    } t_op;

    typedef enum logic [1:0] {
        C_NONE,
        C_IN,
        C_OUT
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  loop_tap;
        t_pc   nxt;
        logic  tap_one;
    } t_uword;

    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_WAIT: w = '{OP_WAIT,  C_IN,   1'b0, PC_MACB, 1'b0};
            PC_MACB: w = '{OP_MAC_B, C_NONE, 1'b1, PC_MACA, 1'b1};
            PC_MACA: w = '{OP_MAC_A, C_NONE, 1'b1, PC_OUT,  1'b0};
            PC_OUT:  w = '{OP_OUT,   C_OUT,  1'b0, PC_GAIN, 1'b0};
            PC_GAIN: w = '{OP_GAIN,  C_NONE, 1'b0, PC_UPDB, 1'b0};
            PC_UPDB: w = '{OP_UPD_B, C_NONE, 1'b1, PC_UPDA, 1'b1};
            PC_UPDA: w = '{OP_UPD_A, C_NONE, 1'b1, PC_WAIT, 1'b0};
            default: w = '{OP_WAIT,  C_NONE, 1'b0, PC_WAIT, 1'b0};
        endcase
        return w;
    endfunction

endpackage

### src/ailms_in_if.sv
interface ailms_in_if #(parameter int W = 16) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] sample_in;
    logic signed [W-1:0] desired_in;

    modport source (output valid, output sample_in, output desired_in, input ready);
    modport sink (input valid, input sample_in, input desired_in, output ready);
endinterface

### src/ailms_out_if.sv
interface ailms_out_if #(parameter int W = 16) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] filtered_out;
    logic signed [W-1:0] error_out;

    modport source (output valid, output filtered_out, output error_out, input ready);
    modport sink (input valid, input filtered_out, input error_out, output ready);
endinterface

### src/adaptive_iir_lms_filter.sv
// Items are processed one at a time: a new input is taken only once the
// coefficient update for the last one is done, as the single shared multiplier
// is stepped over every tap by the microcode sequencer.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) clears histories, coefficients, sequencer
// and output valid, and loads step_size 655 and taps_in_use 4.
module adaptive_iir_lms_filter
    import ailms_pkg::*;
#(
    parameter int MAX_ORDER   = 4,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ailms_in_if.sink              i_in,
    ailms_out_if.source           o_out
);

    localparam int DEPTH    = MAX_ORDER + 1;
    localparam int TAP_W    = $clog2(DEPTH);
    localparam int SB       = SAMPLE_BITS;
    localparam int SF       = SB - 1;
    localparam int CB       = COEF_BITS;
    localparam int CF       = CB - 4;
    localparam int MA_T     = (CB > SB) ? CB : SB;
    localparam int MA_W     = (MA_T > STEP_W + 1) ? MA_T : STEP_W + 1;
    localparam int MUL_W    = MA_W + SB;
    localparam int ACC_NEED = CB + SB + $clog2(2 * DEPTH);
    localparam int ACC_W    = (ACC_NEED > 64) ? 64 : ACC_NEED;
    localparam int RND_W    = (ACC_NEED >= 64) ? 64 : ACC_NEED + 1;
    localparam int WIDE     = (MUL_W > ACC_W) ? MUL_W : ACC_W;
    localparam int S_SH     = 2 * SF - CF;
    localparam int SH_R     = (S_SH > 0) ? S_SH : 0;
    localparam int SH_L     = (S_SH < 0) ? -S_SH : 0;
    localparam int U_HS     = (SH_R > 0) ? SH_R - 1 : 0;
    localparam int UPD_W    = MUL_W + SH_L + 2;

    localparam logic signed [SB-1:0]    S_MAX  = {1'b0, {SF{1'b1}}};
    localparam logic signed [SB-1:0]    S_MIN  = {1'b1, {SF{1'b0}}};
    localparam logic signed [CB-1:0]    C_MAX  = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0]    C_MIN  = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [RND_W-1:0] Y_HALF = RND_W'(1) << (CF - 1);
    localparam logic signed [MUL_W-1:0] G_HALF = MUL_W'(1) << (STEP_FRAC - 1);
    localparam logic signed [UPD_W-1:0] U_HALF = (SH_R > 0) ? (UPD_W'(1) << U_HS) : '0;

    logic [STEP_W-1:0]          r_step;
    logic [TAPS_W-1:0]          r_taps;
    logic signed [SB-1:0]       r_xh [DEPTH];
    logic signed [SB-1:0]       r_yh [DEPTH];
    logic signed [CB-1:0]       r_b [DEPTH];
    logic signed [CB-1:0]       r_a [DEPTH];
    t_pc                        r_pc;
    logic [TAP_W-1:0]           r_tap;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [SB-1:0]       r_d;
    logic signed [SB-1:0]       r_g;
    logic                       r_ov;
    logic signed [SB-1:0]       r_y;
    logic signed [SB-1:0]       r_e;

    t_uword                     uw;
    logic [TAP_W-1:0]           ord;
    logic                       tap_last;
    logic                       in_fire;
    logic                       out_free;
    logic                       go;
    logic                       done;
    logic signed [MA_W-1:0]     mul_a;
    logic signed [SB-1:0]       mul_b;
    logic signed [MUL_W-1:0]    mul;
    logic signed [WIDE-1:0]     prod_wide;
    logic signed [ACC_W-1:0]    prod_acc;
    logic signed [ACC_W-1:0]    acc_sum;
    logic signed [RND_W-1:0]    y_rnd;
    logic signed [RND_W-1:0]    y_sh;
    logic signed [SB-1:0]       y_val;
    logic signed [SB:0]         e_diff;
    logic signed [SB-1:0]       e_val;
    logic signed [MUL_W-1:0]    g_rnd;
    logic signed [SB-1:0]       g_val;
    logic signed [UPD_W-1:0]    u_prod;
    logic signed [UPD_W-1:0]    u_step;
    logic signed [CB-1:0]       u_cf;
    logic signed [UPD_W-1:0]    u_sum;
    logic signed [CB-1:0]       c_new;

    assign uw       = ucode(r_pc);
    assign tap_last = (r_tap == ord);
    assign i_in.ready = (uw.op == OP_WAIT);
    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;

    assign o_out.valid        = r_ov;
    assign o_out.filtered_out = r_y;
    assign o_out.error_out    = r_e;

    always_comb begin
        if (r_taps == '0) begin
            ord = TAP_W'(1);
        end else if (int'(r_taps) > MAX_ORDER) begin
            ord = TAP_W'(MAX_ORDER);
        end else begin
            ord = TAP_W'(r_taps);
        end
    end

    always_comb begin
        case (uw.cond)
            C_IN:    go = in_fire;
            C_OUT:   go = out_free;
            default: go = 1'b1;
        endcase
        done = go && (!uw.loop_tap || tap_last);
    end

    always_comb begin
        unique case (uw.op)
            OP_MAC_B: begin
                mul_a = MA_W'(r_b[r_tap]);
                mul_b = r_xh[r_tap];
            end
            OP_MAC_A: begin
                mul_a = MA_W'(r_a[r_tap]);
                mul_b = r_yh[r_tap - 1'b1];
            end
            OP_GAIN: begin
                mul_a = MA_W'(signed'({1'b0, r_step}));
                mul_b = r_e;
            end
            OP_UPD_B: begin
                mul_a = MA_W'(r_g);
                mul_b = r_xh[r_tap];
            end
            OP_UPD_A: begin
                mul_a = MA_W'(r_g);
                mul_b = r_yh[r_tap];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul = mul_a * mul_b;

    always_comb begin
        prod_wide = WIDE'(mul);
        prod_acc  = signed'(prod_wide[ACC_W-1:0]);
        acc_sum   = (uw.op == OP_MAC_A) ? r_acc - prod_acc : r_acc + prod_acc;
    end

    always_comb begin
        y_rnd = RND_W'(r_acc) + Y_HALF;
        y_sh  = y_rnd >>> CF;
        if (y_sh[RND_W-1:SF] == '0 || y_sh[RND_W-1:SF] == '1) begin
            y_val = y_sh[SB-1:0];
        end else begin
            y_val = y_sh[RND_W-1] ? S_MIN : S_MAX;
        end
        e_diff = {r_d[SB-1], r_d} - {y_val[SB-1], y_val};
        if (e_diff[SB] == e_diff[SB-1]) begin
            e_val = e_diff[SB-1:0];
        end else begin
            e_val = e_diff[SB] ? S_MIN : S_MAX;
        end
    end

    always_comb begin
        g_rnd = (mul + G_HALF) >>> STEP_FRAC;
        g_val = g_rnd[SB-1:0];
    end

    always_comb begin
        u_prod = UPD_W'(mul);
        if (S_SH > 0) begin
            u_step = (u_prod + U_HALF) >>> SH_R;
        end else begin
            u_step = u_prod <<< SH_L;
        end
        u_cf = (uw.op == OP_UPD_A) ? r_a[r_tap] : r_b[r_tap];
        u_sum = (uw.op == OP_UPD_A) ? UPD_W'(u_cf) - u_step : UPD_W'(u_cf) + u_step;
        if (u_sum[UPD_W-1:CB-1] == '0 || u_sum[UPD_W-1:CB-1] == '1) begin
            c_new = u_sum[CB-1:0];
        end else begin
            c_new = u_sum[UPD_W-1] ? C_MIN : C_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RESET;
            r_taps <= TAPS_RESET;
            r_pc   <= PC_WAIT;
            r_tap  <= '0;
            r_ov   <= 1'b0;
            for (int k = 0; k < DEPTH; k++) begin
                r_xh[k] <= '0;
                r_yh[k] <= '0;
                r_b[k]  <= '0;
                r_a[k]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_STEP_SIZE:   r_step <= i_cfg_data[STEP_W-1:0];
                    REG_TAPS_IN_USE: r_taps <= i_cfg_data[TAPS_W-1:0];
                    default: ;
                endcase
            end

            if (o_out.ready) begin
                r_ov <= 1'b0;
            end

            unique case (uw.op) inside
                OP_WAIT: begin
                    if (in_fire) begin
                        for (int k = DEPTH - 1; k > 0; k--) begin
                            r_xh[k] <= r_xh[k-1];
                        end
                        r_xh[0] <= i_in.sample_in;
                        r_d     <= i_in.desired_in;
                        r_acc   <= '0;
                    end
                end
                OP_MAC_B, OP_MAC_A: begin
                    r_acc <= acc_sum;
                end
                OP_OUT: begin
                    if (out_free) begin
                        for (int k = DEPTH - 1; k > 0; k--) begin
                            r_yh[k] <= r_yh[k-1];
                        end
                        r_yh[0] <= y_val;
                        r_y     <= y_val;
                        r_e     <= e_val;
                        r_ov    <= 1'b1;
                    end
                end
                OP_GAIN: begin
                    r_g <= g_val;
                end
                OP_UPD_B: begin
                    r_b[r_tap] <= c_new;
                end
                OP_UPD_A: begin
                    r_a[r_tap] <= c_new;
                end
                default: ;
            endcase

            if (done) begin
                r_pc  <= uw.nxt;
                r_tap <= uw.tap_one ? TAP_W'(1) : '0;
            end else if (go) begin
                r_tap <= r_tap + 1'b1;
            end
        end
    end

endmodule

### src/ailms_chk.sv
module ailms_chk #(
    parameter int W = 16
) (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [W-1:0] i_out_y,
    input logic [W-1:0] i_out_e
);

    logic [1:0] r_pend;
    logic       in_x;
    logic       out_x;

    assign in_x  = i_in_valid && i_in_ready;
    assign out_x = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            case ({in_x, out_x})
                2'b10:   r_pend <= r_pend + 2'd1;
                2'b01:   r_pend <= r_pend - 2'd1;
                default: r_pend <= r_pend;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_y) && $stable(i_out_e))
        else $error("output payload changed while stalled");

    a_no_third: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == 2'd2 |-> !i_in_ready)
        else $error("input taken with two items outstanding");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 2'd0)
        else $error("result offered with no item outstanding");

endmodule

bind adaptive_iir_lms_filter ailms_chk #(.W(SAMPLE_BITS)) u_ailms_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_y     (o_out.filtered_out),
    .i_out_e     (o_out.error_out)
);

### dv/adaptive_iir_lms_filter_tb.sv
`timescale 1ns / 100ps

module adaptive_iir_lms_filter_tb;
    import ailms_pkg::*;

    localparam int MAX_ORD    = 4;
    localparam int SMP_W      = 16;
    localparam int COEF_W     = 24;
    localparam int COEF_FRAC  = COEF_W - 4;
    localparam int RESCALE_SH = 2 * (SMP_W - 1) - COEF_FRAC;
    localparam int SETTLE_CYC = 32;
    localparam int LONG_HOLD  = 300;
    localparam int N_PHASES   = 8;
    localparam int PHASE_LEN  = 66;
    localparam int NDIR       = 33;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        logic signed [SMP_W-1:0] y;
        logic signed [SMP_W-1:0] e;
    } t_filt_res;

    typedef struct packed {
        t_row_kind               kind;
        logic [CFG_ADDR_W-1:0]   addr;
        logic [CFG_DATA_W-1:0]   data;
        logic signed [SMP_W-1:0] x;
        logic signed [SMP_W-1:0] d;
        logic                    chk;
        logic signed [SMP_W-1:0] ey;
        logic signed [SMP_W-1:0] ee;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ailms_in_if  #(.W(SMP_W)) in_if ();
    ailms_out_if #(.W(SMP_W)) out_if ();

    adaptive_iir_lms_filter #(
        .MAX_ORDER   (MAX_ORD),
        .SAMPLE_BITS (SMP_W),
        .COEF_BITS   (COEF_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #10 i_clk = ~i_clk;

    logic signed [SMP_W-1:0]  x_hist [MAX_ORD+1];
    logic signed [SMP_W-1:0]  y_hist [MAX_ORD+1];
    logic signed [COEF_W-1:0] b_coef [MAX_ORD+1];
    logic signed [COEF_W-1:0] a_coef [MAX_ORD+1];
    logic [STEP_W-1:0]        mu;
    logic [TAPS_W-1:0]        order_reg;

    t_filt_res pending_outputs [$];
    int        err_cnt = 0;
    bit        idle_en = 1'b1;
    bit        hold_req = 1'b0;

    t_row dir_tab [NDIR] = '{
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h7FFF, 16'h8000, 1'b1, 16'h0000, 16'h8000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'hFFFF, 16'h0001, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_CFG,  REG_STEP_SIZE,   16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h5555, 16'hAAAA, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'hAAAA, 16'h5555, 1'b0, 16'h0000, 16'h0000},
        '{ROW_CFG,  REG_TAPS_IN_USE, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h7FFF, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h0000, 16'h8000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h0001, 16'hFFFF, 1'b0, 16'h0000, 16'h0000},
        '{ROW_CFG,  REG_TAPS_IN_USE, 16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h7FFF, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h8000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_CFG,  REG_SPARE_2,     16'hFFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_CFG,  REG_SPARE_3,     16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h3039, 16'hCFC7, 1'b0, 16'h0000, 16'h0000},
        '{ROW_CFG,  REG_STEP_SIZE,   16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_CFG,  REG_TAPS_IN_USE, 16'h0005, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h7FFF, 16'h8000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h8000, 16'h7FFF, 1'b0, 16'h0000, 16'h0000},
        '{ROW_CFG,  REG_STEP_SIZE,   16'h0001, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_CFG,  REG_TAPS_IN_USE, 16'hFFFA, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h0064, 16'hFF9C, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h8000, 16'h8000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_CFG,  REG_TAPS_IN_USE, 16'h0001, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_CFG,  REG_STEP_SIZE,   16'h028F, 16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'h4000, 16'hC000, 1'b0, 16'h0000, 16'h0000},
        '{ROW_ITEM, REG_STEP_SIZE,   16'h0000, 16'hC000, 16'h4000, 1'b0, 16'h0000, 16'h0000}
    };

    function automatic longint round_half_up(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        longint lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic t_filt_res predict_filter_output(logic signed [SMP_W-1:0] x,
                                                        logic signed [SMP_W-1:0] d);
        t_filt_res r;
        longint    acc;
        longint    yv;
        longint    ev;
        longint    g;
        int        n;
        int        i;
        if (order_reg == '0) n = 1;
        else if (int'(order_reg) > MAX_ORD) n = MAX_ORD;
        else n = int'(order_reg);

        for (i = MAX_ORD; i > 0; i--) x_hist[i] = x_hist[i-1];
        x_hist[0] = x;

        acc = 0;
        for (i = 0; i <= n; i++) acc += longint'(b_coef[i]) * longint'(x_hist[i]);
        for (i = 1; i <= n; i++) acc -= longint'(a_coef[i]) * longint'(y_hist[i-1]);
        yv = clip(round_half_up(acc, COEF_FRAC), SMP_W);

        for (i = MAX_ORD; i > 0; i--) y_hist[i] = y_hist[i-1];
        y_hist[0] = SMP_W'(yv);

        ev = clip(longint'(d) - yv, SMP_W);
        g  = round_half_up(longint'({1'b0, mu}) * ev, STEP_FRAC);

        for (i = 0; i <= n; i++) begin
            b_coef[i] = COEF_W'(clip(longint'(b_coef[i])
                + round_half_up(g * longint'(x_hist[i]), RESCALE_SH), COEF_W));
            if (i > 0) begin
                a_coef[i] = COEF_W'(clip(longint'(a_coef[i])
                    - round_half_up(g * longint'(y_hist[i]), RESCALE_SH), COEF_W));
            end
        end
        r.y = SMP_W'(yv);
        r.e = SMP_W'(ev);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (addr)
            REG_STEP_SIZE:   mu = data[STEP_W-1:0];
            REG_TAPS_IN_USE: order_reg = data[TAPS_W-1:0];
            default: ;
        endcase
    endtask

    // drop valid, wait for every output, then let the coefficient update finish
    task automatic settle();
        in_if.valid <= 1'b0;
        i_cfg_we    <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic sender_gap();
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            i_cfg_we    <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // hold valid high after the transfer; the caller lowers it
    task automatic send_sample(input logic signed [SMP_W-1:0] x, input logic signed [SMP_W-1:0] d,
                               input logic chk, input logic signed [SMP_W-1:0] ey,
                               input logic signed [SMP_W-1:0] ee);
        t_filt_res r;
        i_cfg_we         <= 1'b0;
        in_if.valid      <= 1'b1;
        in_if.sample_in  <= x;
        in_if.desired_in <= d;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        r = predict_filter_output(x, d);
        if (chk) begin
            r.y = ey;
            r.e = ee;
        end
        pending_outputs.push_back(r);
    endtask

    initial begin : out_sink
        t_filt_res want;
        int        stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (out_if.valid && out_if.ready) begin
                if (pending_outputs.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer y=%0d e=%0d",
                                              out_if.filtered_out, out_if.error_out));
                end else begin
                    want = pending_outputs.pop_front();
                    if (out_if.filtered_out !== want.y)
                        report_mismatch($sformatf("filtered_out got %0d expected %0d",
                                                  out_if.filtered_out, want.y));
                    if (out_if.error_out !== want.e)
                        report_mismatch($sformatf("error_out got %0d expected %0d",
                                                  out_if.error_out, want.e));
                end
            end
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9);
            end
            if (stall_left != 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                out_if.ready <= 1'b1;
            end
            @(posedge i_clk);
        end
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stim
        int                      ph;
        int                      k;
        int                      m;
        int                      i;
        bit                      busy;
        logic [CFG_DATA_W-1:0]   step_v;
        logic [CFG_DATA_W-1:0]   taps_v;
        logic signed [SMP_W-1:0] xs;
        logic signed [SMP_W-1:0] ds;
        logic signed [SMP_W-1:0] prev_x;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_addr       <= '0;
        i_cfg_data       <= '0;
        in_if.valid      <= 1'b0;
        in_if.sample_in  <= '0;
        in_if.desired_in <= '0;

        mu        = STEP_RESET;
        order_reg = TAPS_RESET;
        for (i = 0; i <= MAX_ORD; i++) begin
            x_hist[i] = '0;
            y_hist[i] = '0;
            b_coef[i] = '0;
            a_coef[i] = '0;
        end
        busy   = 1'b0;
        prev_x = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYC) @(posedge i_clk);

        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_CFG) begin
                if (busy) settle();
                busy = 1'b0;
                cfg_write(dir_tab[k].addr, dir_tab[k].data);
            end else begin
                sender_gap();
                send_sample(dir_tab[k].x, dir_tab[k].d, dir_tab[k].chk,
                            dir_tab[k].ey, dir_tab[k].ee);
                busy = 1'b1;
            end
        end

        for (ph = 0; ph < N_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin step_v = 16'd655;   taps_v = 16'd1; end
                1: begin step_v = 16'hFFFF;  taps_v = 16'd4; end
                2: begin step_v = 16'($urandom_range(200, 3000)); taps_v = 16'd0; end
                3: begin step_v = 16'd0;     taps_v = 16'd7; end
                4: begin step_v = 16'd1;     taps_v = 16'($urandom_range(0, 65535)); end
                5: begin
                    step_v = 16'($urandom_range(0, 65535));
                    taps_v = 16'($urandom_range(0, 65535));
                end
                default: begin
                    step_v = 16'($urandom_range(200, 3000));
                    taps_v = 16'($urandom_range(0, 65535));
                end
            endcase
            cfg_write(REG_STEP_SIZE, step_v);
            cfg_write(REG_TAPS_IN_USE, taps_v);
            if ($urandom_range(0, 1) == 1)
                cfg_write($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                          16'($urandom_range(0, 65535)));
            idle_en = (ph != N_PHASES - 1) && ($urandom_range(0, 3) != 0);
            if (ph == 2) hold_req = 1'b1;

            for (k = 0; k < PHASE_LEN; k++) begin
                if (ph == 4 && k == PHASE_LEN / 2) begin
                    in_if.valid <= 1'b0;
                    do @(posedge i_clk); while (pending_outputs.size() != 0);
                end
                m = $urandom_range(0, 9);
                if (m == 0) begin
                    case ($urandom_range(0, 3))
                        0: xs = 16'h7FFF;
                        1: xs = 16'h8000;
                        2: xs = 16'h0000;
                        default: xs = 16'hFFFF;
                    endcase
                end else if (m < 4) begin
                    xs = 16'($urandom_range(0, 65535));
                end else begin
                    xs = 16'(int'($urandom_range(0, 8191)) - 4096);
                end
                if ($urandom_range(0, 1) == 1) ds = (xs >>> 1) + (prev_x >>> 2);
                else ds = 16'($urandom_range(0, 65535));
                prev_x = xs;
                sender_gap();
                send_sample(xs, ds, 1'b0, '0, '0);
            end
        end

        settle();
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### adaptive_iir_lms_filter.f
src/ailms_pkg.sv
src/ailms_in_if.sv
src/ailms_out_if.sv
src/adaptive_iir_lms_filter.sv
src/ailms_chk.sv
dv/adaptive_iir_lms_filter_tb.sv
